>>> src/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared types, codes and helpers for the matrix multiply core.
// ----------------------------------------------------------------------------
package mm_pkg;

   localparam int DEFAULT_MAX_DIM    = 8;
   localparam int DEFAULT_DATA_WIDTH = 16;

   localparam int DIM_WIDTH     = 4;
   localparam int IDX_WIDTH     = 3;
   localparam int PRODUCT_WIDTH = 35;

   // Queue depths between the front end, the engine and the result port.
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_WRITE_A = 2'd0,
      KIND_WRITE_B = 2'd1,
      KIND_START   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_ROWS_A  = 2'd0,
      CSR_INNER_A = 2'd1,
      CSR_ROWS_B  = 2'd2,
      CSR_COLS_B  = 2'd3
   } csr_index_type;

   // Effective (saturated) matrix dimensions.
   typedef struct packed {
      logic [DIM_WIDTH-1:0] rows_a;
      logic [DIM_WIDTH-1:0] inner_a;
      logic [DIM_WIDTH-1:0] rows_b;
      logic [DIM_WIDTH-1:0] cols_b;
   } dims_type;

   typedef struct packed {
      kind_type             kind;
      logic [IDX_WIDTH-1:0] row;
      logic [IDX_WIDTH-1:0] col;
   } cmd_ctl_type;

   typedef struct packed {
      logic [IDX_WIDTH-1:0]            out_row;
      logic [IDX_WIDTH-1:0]            out_col;
      logic signed [PRODUCT_WIDTH-1:0] product;
      logic                            last;
      logic                            mismatch;
   } rsp_type;

   // A zero dimension acts as one, anything above the maximum as the maximum.
   function automatic logic [DIM_WIDTH-1:0] eff_dim(input logic [DIM_WIDTH-1:0] v,
                                                    input logic [DIM_WIDTH-1:0] max_dim);
      logic [DIM_WIDTH-1:0] r;
      if (v == '0) begin
         r = {{(DIM_WIDTH-1){1'b0}}, 1'b1};
      end else if (v > max_dim) begin
         r = max_dim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> src/mm_fifo.sv
// ----------------------------------------------------------------------------
// Matrix multiply queue
// Small synchronous first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module mm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("queue count above depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !(pop && !empty)) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");
`endif

endmodule

>>> src/mm_front.sv
// ----------------------------------------------------------------------------
// Matrix multiply front end
// Holds the dimension registers and filters incoming items into commands.
// ----------------------------------------------------------------------------
module mm_front #(
   parameter int MAX_DIM    = mm_pkg::DEFAULT_MAX_DIM,
   parameter int DATA_WIDTH = mm_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [mm_pkg::DIM_WIDTH-1:0]    csr_data,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [1:0]                      req_kind,
   input  logic [mm_pkg::IDX_WIDTH-1:0]    req_row,
   input  logic [mm_pkg::IDX_WIDTH-1:0]    req_col,
   input  logic signed [DATA_WIDTH-1:0]    req_value,
   output mm_pkg::dims_type                dims,
   output logic                            cmd_push,
   output mm_pkg::cmd_ctl_type             cmd_ctl,
   output logic [DATA_WIDTH-1:0]           cmd_value,
   input  logic                            cmd_full
);

   localparam logic [mm_pkg::DIM_WIDTH-1:0] MAX_D = mm_pkg::DIM_WIDTH'(MAX_DIM);

   logic [mm_pkg::DIM_WIDTH-1:0] rows_a_ff, inner_a_ff, rows_b_ff, cols_b_ff;
   logic                         keep;
   logic [mm_pkg::DIM_WIDTH-1:0] row_w, col_w;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff  <= 4'd1;
         inner_a_ff <= 4'd1;
         rows_b_ff  <= 4'd1;
         cols_b_ff  <= 4'd1;
      end else if (csr_valid) begin
         unique case (mm_pkg::csr_index_type'(csr_index))
            mm_pkg::CSR_ROWS_A:  rows_a_ff  <= csr_data;
            mm_pkg::CSR_INNER_A: inner_a_ff <= csr_data;
            mm_pkg::CSR_ROWS_B:  rows_b_ff  <= csr_data;
            mm_pkg::CSR_COLS_B:  cols_b_ff  <= csr_data;
         endcase
      end
   end

   always_comb begin
      dims.rows_a  = mm_pkg::eff_dim(rows_a_ff, MAX_D);
      dims.inner_a = mm_pkg::eff_dim(inner_a_ff, MAX_D);
      dims.rows_b  = mm_pkg::eff_dim(rows_b_ff, MAX_D);
      dims.cols_b  = mm_pkg::eff_dim(cols_b_ff, MAX_D);
   end

   assign row_w = {1'b0, req_row};
   assign col_w = {1'b0, req_col};

   // Writes outside the current dimensions and unused kinds are dropped here.
   always_comb begin
      unique case (req_kind)
         mm_pkg::KIND_WRITE_A: keep = (row_w < dims.rows_a) && (col_w < dims.inner_a);
         mm_pkg::KIND_WRITE_B: keep = (row_w < dims.rows_b) && (col_w < dims.cols_b);
         mm_pkg::KIND_START:   keep = 1'b1;
         default:              keep = 1'b0;
      endcase
   end

   assign cmd_push     = req_push && !cmd_full && keep;
   assign cmd_ctl.kind = mm_pkg::kind_type'(req_kind);
   assign cmd_ctl.row  = req_row;
   assign cmd_ctl.col  = req_col;
   assign cmd_value    = req_value;

endmodule

>>> src/mm_back.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Owns the two element stores and walks the product through one
// multiply-accumulate unit, pushing each element into the result queue.
// ----------------------------------------------------------------------------
module mm_back #(
   parameter int MAX_DIM    = mm_pkg::DEFAULT_MAX_DIM,
   parameter int DATA_WIDTH = mm_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mm_pkg::dims_type       dims,
   input  logic                   cmd_empty,
   input  mm_pkg::cmd_ctl_type    cmd_ctl,
   input  logic [DATA_WIDTH-1:0]  cmd_value,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output mm_pkg::rsp_type        rsp_data
);

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PW          = mm_pkg::PRODUCT_WIDTH;
   localparam int IW          = mm_pkg::IDX_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [IW-1:0]               i_ff, i_in;
   logic [IW-1:0]               j_ff, j_in;
   logic [IW-1:0]               k_ff, k_in;
   logic signed [PW-1:0]        acc_ff, acc_in;
   logic                        mis_ff, mis_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic                        mul_vld_ff;
   logic signed [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic signed [2*DATA_WIDTH-1:0] mul_ff;

   logic [DATA_WIDTH-1:0] store_a [STORE_DEPTH];
   logic [DATA_WIDTH-1:0] store_b [STORE_DEPTH];

   logic          we_a, we_b;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic          last_elem;
   logic          row_end;
   logic          dim_mismatch;

   assign wr_addr   = AW'(int'(cmd_ctl.row) * MAX_DIM + int'(cmd_ctl.col));
   assign rd_addr_a = AW'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign rd_addr_b = AW'(int'(k_ff) * MAX_DIM + int'(j_ff));

   assign row_end      = ({1'b0, j_ff} + 4'd1) == dims.cols_b;
   assign last_elem    = row_end && (({1'b0, i_ff} + 4'd1) == dims.rows_a);
   assign dim_mismatch = (dims.inner_a != dims.rows_b);

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      mis_in    = mis_ff;
      rd_vld_in = 1'b0;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      we_a      = 1'b0;
      we_b      = 1'b0;
      if (mul_vld_ff) begin
         acc_in = acc_ff + PW'(mul_ff);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_ctl.kind)
                  mm_pkg::KIND_WRITE_A: we_a = 1'b1;
                  mm_pkg::KIND_WRITE_B: we_b = 1'b1;
                  mm_pkg::KIND_START: begin
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     acc_in   = '0;
                     mis_in   = dim_mismatch;
                     state_in = dim_mismatch ? ST_EMIT : ST_MAC;
                  end
                  default: ;
               endcase
            end
         end
         ST_MAC: begin
            rd_vld_in = 1'b1;
            if (({1'b0, k_ff} + 4'd1) == dims.inner_a) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // Wait for the read and multiply stages to retire into the sum.
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               acc_in   = '0;
               if (row_end) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = mis_ff ? ST_EMIT : ST_MAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         mis_ff     <= 1'b0;
         acc_ff     <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= rd_vld_ff;
         mis_ff     <= mis_in;
         acc_ff     <= acc_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         k_ff       <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         store_a[wr_addr] <= cmd_value;
      end
      if (we_b) begin
         store_b[wr_addr] <= cmd_value;
      end
      rd_a_ff <= store_a[rd_addr_a];
      rd_b_ff <= store_b[rd_addr_b];
      mul_ff  <= rd_a_ff * rd_b_ff;
   end

   assign rsp_data.out_row  = i_ff;
   assign rsp_data.out_col  = j_ff;
   assign rsp_data.product  = acc_ff;
   assign rsp_data.last     = last_elem;
   assign rsp_data.mismatch = mis_ff;

`ifndef SYNTH
   a_emit_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!rd_vld_ff && !mul_vld_ff))
      else $error("element emitted with products still in flight");

   a_mismatch_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && mis_ff) |-> (acc_ff == '0))
      else $error("mismatch element carries a nonzero sum");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> ({1'b0, k_ff} < dims.inner_a))
      else $error("inner index beyond inner dimension");
`endif

endmodule

>>> src/matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// Matrix multiply core
// Loads two matrices element by element and streams out their product.
// ----------------------------------------------------------------------------
//  channel | ports                               | handshake
//  --------+-------------------------------------+-----------------------------
//  req     | req_kind/row/col/value              | push & !full
//  rsp     | rsp_out_row/out_col/product/last/.. | pop & !empty
//  csr     | csr_index, csr_data                 | csr_valid & csr_ready (always 1)
//
// An element write leaves the command queue while the engine is idle. A start
// item walks each product element through the single multiply-accumulate
// unit, fed by one read port on each store; with mismatched inner dimensions
// it skips the accumulation. Reset is synchronous and clears control
// state only; store contents stay undefined until written. A full result
// queue stalls the engine, and a full command queue raises req_full.
// ----------------------------------------------------------------------------
module matrix_multiply_core #(
   parameter int MAX_DIM    = mm_pkg::DEFAULT_MAX_DIM,
   parameter int DATA_WIDTH = mm_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [mm_pkg::DIM_WIDTH-1:0]          csr_data,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [1:0]                            req_kind,
   input  logic [mm_pkg::IDX_WIDTH-1:0]          req_row,
   input  logic [mm_pkg::IDX_WIDTH-1:0]          req_col,
   input  logic signed [DATA_WIDTH-1:0]          req_value,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [mm_pkg::IDX_WIDTH-1:0]          rsp_out_row,
   output logic [mm_pkg::IDX_WIDTH-1:0]          rsp_out_col,
   output logic signed [mm_pkg::PRODUCT_WIDTH-1:0] rsp_product,
   output logic                                  rsp_last,
   output logic                                  rsp_mismatch
);

   localparam int CTL_W = $bits(mm_pkg::cmd_ctl_type);
   localparam int CMD_W = CTL_W + DATA_WIDTH;
   localparam int RSP_W = $bits(mm_pkg::rsp_type);

   mm_pkg::dims_type    dims;
   logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
   mm_pkg::cmd_ctl_type cmd_ctl_wr, cmd_ctl_rd;
   logic [DATA_WIDTH-1:0] cmd_value_wr;
   logic [CMD_W-1:0]    cmd_rd_data;
   logic                rsp_push, rsp_full;
   mm_pkg::rsp_type     rsp_wr, rsp_rd;
   logic [RSP_W-1:0]    rsp_rd_data;

   mm_front #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_kind  (req_kind),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .dims      (dims),
      .cmd_push  (cmd_push),
      .cmd_ctl   (cmd_ctl_wr),
      .cmd_value (cmd_value_wr),
      .cmd_full  (cmd_full)
   );

   mm_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (mm_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data ({cmd_ctl_wr, cmd_value_wr}),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   assign cmd_ctl_rd = mm_pkg::cmd_ctl_type'(cmd_rd_data[CMD_W-1 -: CTL_W]);

   mm_back #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .dims      (dims),
      .cmd_empty (cmd_empty),
      .cmd_ctl   (cmd_ctl_rd),
      .cmd_value (cmd_rd_data[DATA_WIDTH-1:0]),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr)
   );

   mm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (mm_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_data),
      .empty   (rsp_empty)
   );

   assign rsp_rd       = mm_pkg::rsp_type'(rsp_rd_data);
   assign rsp_out_row  = rsp_rd.out_row;
   assign rsp_out_col  = rsp_rd.out_col;
   assign rsp_product  = rsp_rd.product;
   assign rsp_last     = rsp_rd.last;
   assign rsp_mismatch = rsp_rd.mismatch;

endmodule

>>> tb/matrix_multiply_core_checker.sv
// ----------------------------------------------------------------------------
// Matrix multiply core checker
// Watches the register, request and result channels of the core, keeps its
// own copy of both matrices and the dimension registers, predicts every
// product element and compares each popped result field by field.
// ----------------------------------------------------------------------------
module matrix_multiply_core_checker #(
   parameter int MAX_DIM    = mm_pkg::DEFAULT_MAX_DIM,
   parameter int DATA_WIDTH = mm_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [1:0]                              csr_index,
   input  logic [mm_pkg::DIM_WIDTH-1:0]            csr_data,
   input  logic                                    req_push,
   input  logic                                    req_full,
   input  logic [1:0]                              req_kind,
   input  logic [mm_pkg::IDX_WIDTH-1:0]            req_row,
   input  logic [mm_pkg::IDX_WIDTH-1:0]            req_col,
   input  logic signed [DATA_WIDTH-1:0]            req_value,
   input  logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   input  logic [mm_pkg::IDX_WIDTH-1:0]            rsp_out_row,
   input  logic [mm_pkg::IDX_WIDTH-1:0]            rsp_out_col,
   input  logic signed [mm_pkg::PRODUCT_WIDTH-1:0] rsp_product,
   input  logic                                    rsp_last,
   input  logic                                    rsp_mismatch,
   input  logic                                    end_of_test,
   output int                                      failures,
   output int                                      pending,
   output int                                      checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import mm_pkg::*;

   localparam int MAX_REPORTS = 40;

   dims_type                     dim_regs;
   logic signed [DATA_WIDTH-1:0] matrix_a [MAX_DIM*MAX_DIM];
   logic signed [DATA_WIDTH-1:0] matrix_b [MAX_DIM*MAX_DIM];
   rsp_type                      predicted_elements [$];
   int                           fail_count = 0;
   int                           element_count = 0;
   bit                           leftovers_reported = 1'b0;

   function automatic int clamp_dim(input logic [DIM_WIDTH-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   task automatic report_error(input string what);
      // Printing stops after a while so that a broken core cannot flood the log.
      if (fail_count < MAX_REPORTS) begin
         $display("%0t: %s", $time, what);
      end
      fail_count++;
   endtask

   task automatic predict_product(input logic [1:0] kind,
                                  input logic [IDX_WIDTH-1:0] row,
                                  input logic [IDX_WIDTH-1:0] col,
                                  input logic signed [DATA_WIDTH-1:0] value);
      int      p;
      int      q;
      int      rb;
      int      r;
      longint  acc;
      rsp_type elem;
      p  = clamp_dim(dim_regs.rows_a);
      q  = clamp_dim(dim_regs.inner_a);
      rb = clamp_dim(dim_regs.rows_b);
      r  = clamp_dim(dim_regs.cols_b);
      case (kind)
         KIND_WRITE_A: begin
            if (row < p && col < q) matrix_a[row*MAX_DIM+col] = value;
         end
         KIND_WRITE_B: begin
            if (row < rb && col < r) matrix_b[row*MAX_DIM+col] = value;
         end
         KIND_START: begin
            for (int i = 0; i < p; i++) begin
               for (int j = 0; j < r; j++) begin
                  acc = 0;
                  // With mismatched inner dimensions the walk is the same but every
                  // element is zero and flagged.
                  if (q == rb) begin
                     for (int k = 0; k < q; k++) begin
                        acc += longint'(matrix_a[i*MAX_DIM+k]) *
                               longint'(matrix_b[k*MAX_DIM+j]);
                     end
                  end
                  elem.out_row  = IDX_WIDTH'(i);
                  elem.out_col  = IDX_WIDTH'(j);
                  elem.product  = acc[PRODUCT_WIDTH-1:0];
                  elem.last     = (i == p - 1) && (j == r - 1);
                  elem.mismatch = (q != rb);
                  predicted_elements = {predicted_elements, elem};
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         dim_regs = '{rows_a: 4'd1, inner_a: 4'd1, rows_b: 4'd1, cols_b: 4'd1};
         predicted_elements.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS_A:  dim_regs.rows_a  = csr_data;
               CSR_INNER_A: dim_regs.inner_a = csr_data;
               CSR_ROWS_B:  dim_regs.rows_b  = csr_data;
               CSR_COLS_B:  dim_regs.cols_b  = csr_data;
               default: begin
               end
            endcase
         end
         if (req_push && !req_full) begin
            predict_product(req_kind, req_row, req_col, req_value);
         end
         if (rsp_pop && !rsp_empty) begin
            if (predicted_elements.size() == 0) begin
               report_error($sformatf("element (%0d,%0d) popped with nothing predicted",
                                      rsp_out_row, rsp_out_col));
            end else begin
               want = predicted_elements.pop_front();
               if (rsp_out_row !== want.out_row) begin
                  report_error($sformatf("out_row %0d, expected %0d", rsp_out_row,
                                         want.out_row));
               end
               if (rsp_out_col !== want.out_col) begin
                  report_error($sformatf("out_col %0d, expected %0d", rsp_out_col,
                                         want.out_col));
               end
               if (rsp_product !== want.product) begin
                  report_error($sformatf("element (%0d,%0d) product %0d, expected %0d",
                                         want.out_row, want.out_col, rsp_product,
                                         want.product));
               end
               if (rsp_last !== want.last) begin
                  report_error($sformatf("element (%0d,%0d) last %b, expected %b",
                                         want.out_row, want.out_col, rsp_last, want.last));
               end
               if (rsp_mismatch !== want.mismatch) begin
                  report_error($sformatf("element (%0d,%0d) mismatch %b, expected %b",
                                         want.out_row, want.out_col, rsp_mismatch,
                                         want.mismatch));
               end
               element_count++;
            end
         end
         if (end_of_test && !leftovers_reported) begin
            if (predicted_elements.size() != 0) begin
               report_error($sformatf("%0d predicted elements never came out",
                                      predicted_elements.size()));
            end
            leftovers_reported = 1'b1;
         end
      end
      failures <= fail_count;
      pending  <= predicted_elements.size();
      checked  <= element_count;
   end

endmodule

>>> tb/matrix_multiply_core_test.sv
// ----------------------------------------------------------------------------
// Matrix multiply core testbench
// Loads matrices and starts products under a series of dimension settings,
// from a short directed opening through random phases with sender gaps,
// receiver stalls and a long receiver hold-off. The checker beside the core
// predicts and compares every product element.
// ----------------------------------------------------------------------------
module matrix_multiply_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mm_pkg::*;

   localparam int         MAX_DIM         = DEFAULT_MAX_DIM;
   localparam int         DATA_WIDTH      = DEFAULT_DATA_WIDTH;
   localparam logic [1:0] KIND_UNUSED     = 2'd3;
   localparam int         ITEMS_PER_PHASE = 25;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         SETTLE_CYCLES   = 16;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [1:0]                           csr_index = '0;
   logic [DIM_WIDTH-1:0]                 csr_data = '0;
   logic                                 req_push = 1'b0;
   logic                                 req_full;
   logic [1:0]                           req_kind = '0;
   logic [IDX_WIDTH-1:0]                 req_row = '0;
   logic [IDX_WIDTH-1:0]                 req_col = '0;
   logic signed [DATA_WIDTH-1:0]         req_value = '0;
   logic                                 rsp_empty;
   logic                                 rsp_pop = 1'b0;
   logic [IDX_WIDTH-1:0]                 rsp_out_row;
   logic [IDX_WIDTH-1:0]                 rsp_out_col;
   logic signed [PRODUCT_WIDTH-1:0]      rsp_product;
   logic                                 rsp_last;
   logic                                 rsp_mismatch;
   logic                                 end_of_test = 1'b0;
   logic                                 hold_off = 1'b0;
   int                                   failures;
   int                                   pending;
   int                                   checked;

   // Effective dimensions of the current setting and which store entries hold data.
   int p_dim = 1;
   int q_dim = 1;
   int rb_dim = 1;
   int r_dim = 1;
   bit loaded_a [MAX_DIM*MAX_DIM];
   bit loaded_b [MAX_DIM*MAX_DIM];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int loads_and_starts = 0;
   int starts_sent = 0;
   int settings_used = 0;

   matrix_multiply_core DUT (.*);

   matrix_multiply_core_checker product_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_pop <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   function automatic int clamp_dim(input logic [DIM_WIDTH-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic [DIM_WIDTH-1:0] random_dim_value();
      int pick = $urandom_range(99);
      if (pick < 70) return DIM_WIDTH'($urandom_range(1, 3));
      if (pick < 80) return '0;
      if (pick < 90) return DIM_WIDTH'($urandom_range(4, MAX_DIM));
      return DIM_WIDTH'($urandom_range(MAX_DIM + 1, 15));
   endfunction

   function automatic dims_type random_dims();
      dims_type d;
      d.rows_a  = random_dim_value();
      d.inner_a = random_dim_value();
      d.cols_b  = random_dim_value();
      // Mostly matching inner dimensions, so that real products dominate.
      d.rows_b  = ($urandom_range(3) == 0) ? random_dim_value() : d.inner_a;
      return d;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [IDX_WIDTH-1:0] row,
                            input logic [IDX_WIDTH-1:0] col,
                            input logic signed [DATA_WIDTH-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_kind  <= kind;
      req_row   <= row;
      req_col   <= col;
      req_value <= value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (kind == KIND_WRITE_A && row < p_dim && col < q_dim) begin
         loaded_a[row*MAX_DIM+col] = 1'b1;
         loads_and_starts++;
      end else if (kind == KIND_WRITE_B && row < rb_dim && col < r_dim) begin
         loaded_b[row*MAX_DIM+col] = 1'b1;
         loads_and_starts++;
      end else if (kind == KIND_START) begin
         starts_sent++;
         loads_and_starts++;
      end
   endtask

   task automatic random_item(input int start_pct);
      int                           pick;
      logic [1:0]                   kind;
      logic [IDX_WIDTH-1:0]         row;
      logic [IDX_WIDTH-1:0]         col;
      logic signed [DATA_WIDTH-1:0] value;
      pick  = $urandom_range(99);
      kind  = KIND_UNUSED;
      row   = IDX_WIDTH'($urandom_range(MAX_DIM - 1));
      col   = IDX_WIDTH'($urandom_range(MAX_DIM - 1));
      value = DATA_WIDTH'($urandom);
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(2))
            0: value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1: value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            default: value = '0;
         endcase
      end
      if (pick < start_pct) begin
         kind = KIND_START;
         // A start must never read an entry that was not loaded, so the first
         // missing operand is loaded in its place.
         if (q_dim == rb_dim) begin
            for (int i = 0; i < p_dim; i++) begin
               for (int k = 0; k < q_dim; k++) begin
                  if (kind == KIND_START && !loaded_a[i*MAX_DIM+k]) begin
                     kind = KIND_WRITE_A;
                     row  = IDX_WIDTH'(i);
                     col  = IDX_WIDTH'(k);
                  end
               end
            end
            for (int k = 0; k < rb_dim; k++) begin
               for (int j = 0; j < r_dim; j++) begin
                  if (kind == KIND_START && !loaded_b[k*MAX_DIM+j]) begin
                     kind = KIND_WRITE_B;
                     row  = IDX_WIDTH'(k);
                     col  = IDX_WIDTH'(j);
                  end
               end
            end
         end
      end else if (pick < 85) begin
         if ($urandom_range(1) == 0) begin
            kind = KIND_WRITE_A;
            row  = IDX_WIDTH'($urandom_range(p_dim - 1));
            col  = IDX_WIDTH'($urandom_range(q_dim - 1));
         end else begin
            kind = KIND_WRITE_B;
            row  = IDX_WIDTH'($urandom_range(rb_dim - 1));
            col  = IDX_WIDTH'($urandom_range(r_dim - 1));
         end
      end else if (pick < 95) begin
         // Anywhere in the index range; most of these fall outside the matrix.
         kind = ($urandom_range(1) == 0) ? KIND_WRITE_A : KIND_WRITE_B;
      end
      send_item(kind, row, col, value);
   endtask

   // Waits until every predicted element is out, then lets queued loads drain.
   task automatic settle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_dims(input dims_type raw);
      csr_index_type regs [4] = '{CSR_ROWS_A, CSR_INNER_A, CSR_ROWS_B, CSR_COLS_B};
      foreach (regs[n]) begin
         csr_valid <= 1'b1;
         csr_index <= regs[n];
         case (regs[n])
            CSR_ROWS_A:  csr_data <= raw.rows_a;
            CSR_INNER_A: csr_data <= raw.inner_a;
            CSR_ROWS_B:  csr_data <= raw.rows_b;
            default:     csr_data <= raw.cols_b;
         endcase
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      p_dim  = clamp_dim(raw.rows_a);
      q_dim  = clamp_dim(raw.inner_a);
      rb_dim = clamp_dim(raw.rows_b);
      r_dim  = clamp_dim(raw.cols_b);
      settings_used++;
   endtask

   task automatic run_phase(input dims_type raw, input int idle_send, input int idle_recv,
                            input int start_pct, input bit pressure);
      int target;
      settle();
      program_dims(raw);
      send_idle_pct = idle_send;
      stall_pct     = idle_recv;
      target        = loads_and_starts + ITEMS_PER_PHASE;
      fork
         begin
            if (pressure) begin
               hold_off <= 1'b1;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               hold_off <= 1'b0;
            end
         end
         begin
            while (loads_and_starts < target) random_item(start_pct);
            req_push <= 1'b0;
         end
      join
   endtask

   initial begin
      #8ms;
      $display("[matrix_multiply_core] ERROR");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset dimensions are all one: extreme operands, ignored fields on a
      // start, writes outside the matrix and the unused kind.
      send_item(KIND_WRITE_A, 3'd0, 3'd0, 16'sh8000);
      send_item(KIND_WRITE_B, 3'd0, 3'd0, 16'sh8000);
      send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
      send_item(KIND_WRITE_B, 3'd0, 3'd0, 16'sh7fff);
      send_item(KIND_START, 3'd7, 3'd7, 16'shffff);
      send_item(KIND_WRITE_A, 3'd1, 3'd0, 16'sh1234);
      send_item(KIND_WRITE_B, 3'd0, 3'd7, 16'sh4321);
      send_item(KIND_UNUSED, 3'd5, 3'd2, 16'sh5555);
      send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
      req_push <= 1'b0;

      // Saturated and zero registers with differing inner dimensions: an 8 by 8
      // walk of flagged zeros.
      settle();
      program_dims('{rows_a: 4'd15, inner_a: 4'd0, rows_b: 4'd2, cols_b: 4'd8});
      send_item(KIND_WRITE_A, 3'd7, 3'd0, 16'sh7fff);
      send_item(KIND_WRITE_B, 3'd1, 3'd7, 16'sh8000);
      send_item(KIND_WRITE_B, 3'd7, 3'd0, 16'sh0101);
      send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
      req_push <= 1'b0;

      run_phase(random_dims(), 0, 0, 20, 1'b0);
      run_phase('{rows_a: 4'd8, inner_a: 4'd1, rows_b: 4'd1, cols_b: 4'd8}, 82, 0, 20, 1'b0);
      run_phase('{rows_a: 4'd1, inner_a: 4'd8, rows_b: 4'd15, cols_b: 4'd1}, 0, 82, 20, 1'b0);
      run_phase(random_dims(), 32, 32, 20, 1'b0);
      run_phase('{rows_a: 4'd2, inner_a: 4'd2, rows_b: 4'd2, cols_b: 4'd2}, 0, 0, 50, 1'b1);
      run_phase('{rows_a: 4'd3, inner_a: 4'd1, rows_b: 4'd0, cols_b: 4'd0}, 0, 82, 20, 1'b0);
      run_phase(random_dims(), 32, 32, 20, 1'b0);

      settle();
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Sent %0d loads and starts (%0d starts) under %0d dimension settings.",
               loads_and_starts, starts_sent, settings_used);
      $display("Compared %0d product elements with their predicted values.", checked);
      if (failures == 0) begin
         $display("[matrix_multiply_core] OK");
      end else begin
         $display("[matrix_multiply_core] ERROR");
      end
      $finish;
   end

endmodule

>>> matrix_multiply_core.f
src/mm_pkg.sv
src/mm_fifo.sv
src/mm_front.sv
src/mm_back.sv
src/matrix_multiply_core.sv
tb/matrix_multiply_core_checker.sv
tb/matrix_multiply_core_test.sv
